// ----- hdl/ors_pkg.sv -----
// Shared types and codes for the 1-Wire search ROM engine.
// Used by ors_search and onewire_rom_search; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ors_pkg;

    localparam int unsigned ROM_BITS     = 64;
    localparam int unsigned BIT_NUM_W    = 7;
    localparam int unsigned ROM_BITS_END = 65;

    typedef enum logic [1:0] {
        CMD_START      = 2'd0,
        CMD_RESET_DONE = 2'd1,
        CMD_BIT_PAIR   = 2'd2,
        CMD_READ       = 2'd3
    } ors_cmd_t;

    typedef enum logic [1:0] {
        ACT_NONE     = 2'd0,
        ACT_BUS_RST  = 2'd1,
        ACT_SEARCH   = 2'd2,
        ACT_FINISHED = 2'd3
    } ors_action_t;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_NOT_READY = 3'd1,
        ST_NO_RESP   = 3'd2,
        ST_BAD_RESP  = 3'd3,
        ST_NO_DEVICE = 3'd4
    } ors_status_t;

    localparam logic [1:0] RST_PRESENCE_OK = 2'd0;

    typedef struct packed {
        ors_cmd_t   cmd;
        logic [1:0] reset_status;
        logic       id_bit;
        logic       cmp_bit;
        logic [2:0] entry_index;
    } ors_item_t;

    typedef struct packed {
        logic          write_dir;
        logic          dir_bit;
        logic          found;
        logic [63:0]   rom_value;
        logic [2:0]    rom_index;
        logic          entry_valid;
        ors_action_t   next_action;
        ors_status_t   status;
        logic [3:0]    device_count;
    } ors_result_t;

endpackage

`default_nettype wire

// ----- hdl/onewire_rom_search.sv -----
// 1-Wire search ROM engine.
//
// Input stream (s_*): one word per command. s_tuser carries the command
// (start, reset outcome, bit pair, read table entry); s_tdata carries the
// reset outcome, the id/complement bit pair and the table index.
// Output stream (m_*): exactly one result word per input word, in order:
// direction bit to write, found ROM and slot, next bus action, finish
// status and device count.
// m_tvalid rises in the cycle after the accept. A new word is accepted every
// cycle, including while the previous result is presented, as long as the
// output register is empty or being drained in the same cycle.
// The device table sits in a RAM with registered read; a table read
// is issued at accept and its data lands with the result word. Table writes
// complete at the accepting edge, so a following read sees them.
// Reset clears the search control state, the device count and all valid marks.
// When m_tready is low while a result is presented, the result holds and s_tready drops.
`timescale 1ns / 1ps
`default_nettype none

module onewire_rom_search #(
    parameter int MAX_DEVICES = 8
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // [1:0] reset_status, [2] id_bit, [3] cmp_bit, [6:4] entry_index, [7] zero
    input  wire logic [7:0]  s_tdata,
    // [1:0] cmd
    input  wire logic [1:0]  s_tuser,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // [0] write_dir, [1] dir_bit, [2] found, [66:3] rom_value, [69:67] rom_index,
    // [70] entry_valid, [72:71] next_action, [75:73] status, [79:76] device_count
    output logic [79:0]      m_tdata
);

    localparam int AW = (MAX_DEVICES > 1) ? $clog2(MAX_DEVICES) : 1;
    localparam int CW = $clog2(MAX_DEVICES + 1);

    ors_pkg::ors_item_t   item;
    ors_pkg::ors_result_t result;
    ors_pkg::ors_result_t res_reg;
    logic                 out_valid_reg;
    logic                 use_ram_reg;
    logic                 accept;
    logic                 tbl_wr_en;
    logic [AW-1:0]        tbl_wr_addr;
    logic [63:0]          tbl_wr_data;
    logic [AW-1:0]        tbl_rd_addr;
    logic [63:0]          tbl_rd_data;
    logic [63:0]          rom_out;

    assign s_tready = !out_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    assign item.cmd          = ors_pkg::ors_cmd_t'(s_tuser);
    assign item.reset_status = s_tdata[1:0];
    assign item.id_bit       = s_tdata[2];
    assign item.cmp_bit      = s_tdata[3];
    assign item.entry_index  = s_tdata[6:4];

    ors_search #(
        .MAX_DEVICES (MAX_DEVICES),
        .AW          (AW),
        .CW          (CW)
    ) u_search (
        .clk         (clk),
        .rst_n       (rst_n),
        .item_valid  (accept),
        .item        (item),
        .result      (result),
        .tbl_wr_en   (tbl_wr_en),
        .tbl_wr_addr (tbl_wr_addr),
        .tbl_wr_data (tbl_wr_data),
        .tbl_rd_addr (tbl_rd_addr)
    );

    ors_ram #(
        .WIDTH (64),
        .DEPTH (MAX_DEVICES),
        .AW    (AW)
    ) u_table (
        .clk     (clk),
        .wr_en   (tbl_wr_en),
        .wr_addr (tbl_wr_addr),
        .wr_data (tbl_wr_data),
        .rd_en   (accept),
        .rd_addr (tbl_rd_addr),
        .rd_data (tbl_rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            out_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            res_reg     <= result;
            use_ram_reg <= (item.cmd == ors_pkg::CMD_READ) && result.entry_valid;
        end
    end

    // read data stays put until the next accept, so it is stable while stalled
    assign rom_out  = use_ram_reg ? tbl_rd_data : res_reg.rom_value;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {res_reg.device_count, res_reg.status, res_reg.next_action,
                       res_reg.entry_valid, res_reg.rom_index, rom_out,
                       res_reg.found, res_reg.dir_bit, res_reg.write_dir};

endmodule

`default_nettype wire

// ----- hdl/ors_ram.sv -----
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module ors_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 8,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             wr_en,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic             rd_en,
    input  wire logic [AW-1:0]    rd_addr,
    output logic      [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ----- hdl/ors_search.sv -----
// Search state and last-discrepancy logic; produces one result per word and
// the device table write. Depends on ors_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ors_search #(
    parameter int MAX_DEVICES = 8,
    parameter int AW = (MAX_DEVICES > 1) ? $clog2(MAX_DEVICES) : 1,
    parameter int CW = $clog2(MAX_DEVICES + 1)
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               item_valid,
    input  wire ors_pkg::ors_item_t item,
    output ors_pkg::ors_result_t    result,
    output logic                    tbl_wr_en,
    output logic [AW-1:0]           tbl_wr_addr,
    output logic [63:0]             tbl_wr_data,
    output logic [AW-1:0]           tbl_rd_addr
);

    localparam int IW = (AW > 3) ? AW : 3;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_WAIT_RESET,
        PH_BITS
    } phase_t;

    phase_t                           phase_reg, phase_next;
    logic [ors_pkg::BIT_NUM_W-1:0]    bit_num_reg, bit_num_next;
    logic [ors_pkg::BIT_NUM_W-1:0]    last_disc_reg, last_disc_next;
    logic [ors_pkg::BIT_NUM_W-1:0]    last_zero_reg, last_zero_next;
    logic                             last_dev_reg, last_dev_next;
    logic [63:0]                      rom_reg, rom_next;
    logic [CW-1:0]                    count_reg, count_next;
    logic [MAX_DEVICES-1:0]           valid_reg, valid_next;

    logic [IW-1:0] eidx_ext;
    logic          eidx_in_range;
    logic [5:0]    pos;
    logic          dir;
    logic [ors_pkg::BIT_NUM_W-1:0] bit_num_inc;

    assign eidx_ext      = IW'(item.entry_index);
    assign tbl_rd_addr   = eidx_ext[AW-1:0];
    assign eidx_in_range = (32'(item.entry_index) < MAX_DEVICES);
    assign pos           = 6'(bit_num_reg - 7'd1);
    assign bit_num_inc   = bit_num_reg + 7'd1;

    // direction: forced by the bus unless both branches exist
    always_comb
    begin
        if (item.id_bit != item.cmp_bit)
        begin
            dir = item.id_bit;
        end
        else if (bit_num_reg < last_disc_reg)
        begin
            dir = rom_reg[pos];
        end
        else
        begin
            dir = (bit_num_reg == last_disc_reg);
        end
    end

    always_comb
    begin
        phase_next     = phase_reg;
        bit_num_next   = bit_num_reg;
        last_disc_next = last_disc_reg;
        last_zero_next = last_zero_reg;
        last_dev_next  = last_dev_reg;
        rom_next       = rom_reg;
        count_next     = count_reg;
        valid_next     = valid_reg;
        tbl_wr_en      = 1'b0;
        tbl_wr_addr    = count_reg[AW-1:0];
        tbl_wr_data    = rom_reg;
        result         = '0;

        unique case (item.cmd)
            ors_pkg::CMD_START:
            begin
                count_next         = '0;
                last_disc_next     = '0;
                last_dev_next      = 1'b0;
                bit_num_next       = 7'd1;
                last_zero_next     = '0;
                phase_next         = PH_WAIT_RESET;
                result.next_action = ors_pkg::ACT_BUS_RST;
            end
            ors_pkg::CMD_RESET_DONE:
            begin
                if (phase_reg == PH_WAIT_RESET)
                begin
                    if (item.reset_status == ors_pkg::RST_PRESENCE_OK)
                    begin
                        phase_next         = PH_BITS;
                        result.next_action = ors_pkg::ACT_SEARCH;
                    end
                    else
                    begin
                        phase_next         = PH_IDLE;
                        result.next_action = ors_pkg::ACT_FINISHED;
                        result.status      = ors_pkg::ors_status_t'({1'b0, item.reset_status});
                    end
                end
            end
            ors_pkg::CMD_BIT_PAIR:
            begin
                if (phase_reg == PH_BITS)
                begin
                    if (item.id_bit && item.cmp_bit)
                    begin
                        phase_next         = PH_IDLE;
                        result.next_action = ors_pkg::ACT_FINISHED;
                        result.status      = ors_pkg::ST_NO_DEVICE;
                    end
                    else
                    begin
                        if ((item.id_bit == item.cmp_bit) && !dir)
                        begin
                            last_zero_next = bit_num_reg;
                        end
                        rom_next[pos]    = dir;
                        result.write_dir = 1'b1;
                        result.dir_bit   = dir;
                        bit_num_next     = bit_num_inc;
                        if (bit_num_inc >= 7'(ors_pkg::ROM_BITS_END))
                        begin
                            last_disc_next = last_zero_next;
                            if (last_zero_next == '0)
                            begin
                                last_dev_next = 1'b1;
                            end
                            if (count_reg < CW'(MAX_DEVICES))
                            begin
                                tbl_wr_en   = 1'b1;
                                tbl_wr_data = rom_next;
                                valid_next[count_reg[AW-1:0]] = 1'b1;
                                count_next  = count_reg + 1'b1;
                            end
                            result.found     = 1'b1;
                            result.rom_value = rom_next;
                            result.rom_index = 3'(count_reg);
                            if (last_dev_next || (count_next >= CW'(MAX_DEVICES)))
                            begin
                                phase_next         = PH_IDLE;
                                result.next_action = ors_pkg::ACT_FINISHED;
                                result.status      = ors_pkg::ST_OK;
                            end
                            else
                            begin
                                bit_num_next       = 7'd1;
                                last_zero_next     = '0;
                                phase_next         = PH_WAIT_RESET;
                                result.next_action = ors_pkg::ACT_BUS_RST;
                            end
                        end
                    end
                end
            end
            ors_pkg::CMD_READ:
            begin
                // table data itself arrives from the RAM in the following cycle
                result.rom_index   = item.entry_index;
                result.entry_valid = eidx_in_range && valid_reg[tbl_rd_addr];
            end
            default:
            begin
            end
        endcase

        result.device_count = 4'(count_next);
        if (!item_valid)
        begin
            tbl_wr_en = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            bit_num_reg   <= 7'd1;
            last_disc_reg <= '0;
            last_zero_reg <= '0;
            last_dev_reg  <= 1'b0;
            count_reg     <= '0;
            valid_reg     <= '0;
        end
        else if (item_valid)
        begin
            phase_reg     <= phase_next;
            bit_num_reg   <= bit_num_next;
            last_disc_reg <= last_disc_next;
            last_zero_reg <= last_zero_next;
            last_dev_reg  <= last_dev_next;
            count_reg     <= count_next;
            valid_reg     <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_valid)
        begin
            rom_reg <= rom_next;
        end
    end

endmodule

`default_nettype wire
